>>> sv/wmm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wmm_pkg;

    localparam int MASK_LEN     = 32;
    localparam int LIVE_W       = MASK_LEN + 1;
    localparam int LEN_W        = $clog2(MASK_LEN + 1);
    localparam int IDX_W        = $clog2(MASK_LEN);
    localparam int CLOSE_LEVELS = $clog2(LIVE_W);

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_NAME   = 2'd2,
        CMD_END    = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic matched;
        logic mask_overflow;
    } result_t;

    typedef logic [LIVE_W-1:0] live_t;

    typedef struct packed {
        logic clear;
        logic append;
    } store_ctl_t;

    typedef struct packed {
        logic restart;
        logic consume;
    } nfa_ctl_t;

    typedef struct packed {
        logic [MASK_LEN-1:0]       star;
        logic [MASK_LEN-1:0]       qmark;
        logic [MASK_LEN-1:0]       used;
        logic [MASK_LEN-1:0][7:0]  lbyte;
        logic [LEN_W-1:0]          len;
    } mask_view_t;

    function automatic logic [7:0] lower_byte(input logic [7:0] c);
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
        begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

    // Segmented prefix OR: a live position spreads forward across each run of stars.
    function automatic live_t star_closure(input live_t s, input logic [MASK_LEN-1:0] star);
        live_t g;
        live_t pr;
        live_t g_prev;
        live_t pr_prev;
        g  = s;
        pr = {star, 1'b0};
        for (int lvl = 0; lvl < CLOSE_LEVELS; lvl++)
        begin
            g_prev  = g;
            pr_prev = pr;
            for (int q = 0; q < LIVE_W; q++)
            begin
                if (q >= (1 << lvl))
                begin
                    g[q]  = g_prev[q] | (pr_prev[q] & g_prev[q - (1 << lvl)]);
                    pr[q] = pr_prev[q] & pr_prev[q - (1 << lvl)];
                end
            end
        end
        return g;
    endfunction

endpackage

`default_nettype wire

>>> sv/wmm_mask_store.sv
`timescale 1ns / 1ps
`default_nettype none

module wmm_mask_store (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire wmm_pkg::store_ctl_t ctl,
    input  wire logic [7:0]          data,
    output wmm_pkg::mask_view_t      view,
    output logic                     overflow
);

    logic [wmm_pkg::LEN_W-1:0]         len_reg;
    logic [wmm_pkg::LEN_W-1:0]         len_next;
    logic                              ovf_reg;
    logic                              ovf_next;
    logic [wmm_pkg::MASK_LEN-1:0][7:0] lbyte_reg;
    logic [wmm_pkg::MASK_LEN-1:0]      star_reg;
    logic [wmm_pkg::MASK_LEN-1:0]      qmark_reg;
    logic                              has_room;

    assign has_room = len_reg < wmm_pkg::LEN_W'(wmm_pkg::MASK_LEN);

    always_comb
    begin
        len_next = len_reg;
        ovf_next = ovf_reg;
        if (ctl.clear)
        begin
            len_next = '0;
            ovf_next = 1'b0;
        end
        else if (ctl.append)
        begin
            if (has_room)
            begin
                len_next = len_reg + 1'b1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            len_reg <= len_next;
            ovf_reg <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.append && has_room)
        begin
            lbyte_reg[len_reg[wmm_pkg::IDX_W-1:0]] <= wmm_pkg::lower_byte(data);
            star_reg[len_reg[wmm_pkg::IDX_W-1:0]]  <= (data == wmm_pkg::CH_STAR);
            qmark_reg[len_reg[wmm_pkg::IDX_W-1:0]] <= (data == wmm_pkg::CH_QMARK);
        end
    end

    always_comb
    begin
        for (int p = 0; p < wmm_pkg::MASK_LEN; p++)
        begin
            view.used[p] = wmm_pkg::LEN_W'(p) < len_reg;
        end
        view.star  = star_reg & view.used;
        view.qmark = qmark_reg & view.used;
        view.lbyte = lbyte_reg;
        view.len   = len_reg;
    end

    assign overflow = ovf_reg;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= wmm_pkg::LEN_W'(wmm_pkg::MASK_LEN))
        else $error("mask length beyond capacity");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> len_reg == wmm_pkg::LEN_W'(wmm_pkg::MASK_LEN))
        else $error("overflow flagged while the mask is not full");

    a_append_grow: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.append && !ctl.clear && has_room |=> len_reg == $past(len_reg) + 1'b1)
        else $error("append did not grow the mask");

endmodule

`default_nettype wire

>>> sv/wmm_nfa.sv
`timescale 1ns / 1ps
`default_nettype none

module wmm_nfa (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire wmm_pkg::nfa_ctl_t   ctl,
    input  wire logic [7:0]          data,
    input  wire wmm_pkg::mask_view_t view,
    output logic                     hit
);

    wmm_pkg::live_t live_reg;
    wmm_pkg::live_t live_next;
    wmm_pkg::live_t closed;
    wmm_pkg::live_t stepped;
    logic [7:0]     lc;

    assign closed = wmm_pkg::star_closure(live_reg, view.star);
    assign lc     = wmm_pkg::lower_byte(data);
    assign hit    = closed[view.len];

    always_comb
    begin
        stepped = '0;
        for (int p = 0; p < wmm_pkg::MASK_LEN; p++)
        begin
            if (closed[p] && view.star[p])
            begin
                stepped[p] = 1'b1;
            end
            if (closed[p] && view.used[p] && !view.star[p]
                && (view.qmark[p] || view.lbyte[p] == lc))
            begin
                stepped[p + 1] = 1'b1;
            end
        end
    end

    always_comb
    begin
        live_next = live_reg;
        if (ctl.restart)
        begin
            live_next = wmm_pkg::LIVE_W'(1);
        end
        else if (ctl.consume)
        begin
            live_next = stepped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= wmm_pkg::LIVE_W'(1);
        end
        else
        begin
            live_reg <= live_next;
        end
    end

    a_restart_start: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.restart |=> live_reg == wmm_pkg::LIVE_W'(1))
        else $error("name restart did not leave only the first position live");

    a_live_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (live_reg >> view.len) <= wmm_pkg::LIVE_W'(1))
        else $error("live position beyond the end of the mask");

    a_dead_stays: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg == '0 && !ctl.restart |=> live_reg == '0)
        else $error("dead match state came back to life");

endmodule

`default_nettype wire

>>> sv/wildcard_mask_match_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// A result is registered when its end-of-name item leaves the input register.
// One item per cycle while no stalled result holds an end-of-name item; live positions are registered per name byte.
// An end-of-name item waits in the input register only while an earlier result is stalled.
// Reset empties the mask, clears the overflow flag and restarts the name.
// The mask byte storage itself is not cleared by reset.

module wildcard_mask_match_unit (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire wmm_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output wmm_pkg::result_t      result
);

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    wmm_pkg::item_t       s1_item_reg;
    logic                 s1_fire;
    logic                 end_fire;
    logic                 res_valid_reg;
    logic                 res_valid_next;
    wmm_pkg::result_t     res_reg;
    wmm_pkg::store_ctl_t  store_ctl;
    wmm_pkg::nfa_ctl_t    nfa_ctl;
    wmm_pkg::mask_view_t  view;
    logic                 overflow;
    logic                 hit;

    assign s1_fire = s1_valid_reg
        && (s1_item_reg.cmd != wmm_pkg::CMD_END || !res_valid_reg || !result_stall);
    assign item_stall = s1_valid_reg && !s1_fire;
    assign end_fire = s1_fire && s1_item_reg.cmd == wmm_pkg::CMD_END;

    always_comb
    begin
        store_ctl = '0;
        nfa_ctl   = '0;
        if (s1_fire)
        begin
            unique case (s1_item_reg.cmd)
                wmm_pkg::CMD_CLEAR:
                begin
                    store_ctl.clear = 1'b1;
                    nfa_ctl.restart = 1'b1;
                end
                wmm_pkg::CMD_APPEND:
                begin
                    store_ctl.append = 1'b1;
                    nfa_ctl.restart  = 1'b1;
                end
                wmm_pkg::CMD_NAME:
                begin
                    nfa_ctl.consume = 1'b1;
                end
                wmm_pkg::CMD_END:
                begin
                    nfa_ctl.restart = 1'b1;
                end
                default:
                begin
                    nfa_ctl.restart = 1'b0;
                end
            endcase
        end
    end

    wmm_mask_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (store_ctl),
        .data     (s1_item_reg.data),
        .view     (view),
        .overflow (overflow)
    );

    wmm_nfa u_nfa (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (nfa_ctl),
        .data  (s1_item_reg.data),
        .view  (view),
        .hit   (hit)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (item_valid && !item_stall)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (end_fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            s1_item_reg <= item;
        end
        if (end_fire)
        begin
            res_reg.matched       <= hit && !overflow;
            res_reg.mask_overflow <= overflow;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        end_fire |=> result_valid)
        else $error("end-of-name item produced no result");

    a_stall_only_held: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> s1_valid_reg && s1_item_reg.cmd == wmm_pkg::CMD_END
            && res_valid_reg && result_stall)
        else $error("input stalled without a blocked result");

    a_no_match_on_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.matched |-> !result.mask_overflow)
        else $error("match reported with an overflowed mask");

    a_result_from_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(end_fire))
        else $error("result appeared without an end-of-name item");

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             item_valid = 1'b0;
    logic             item_stall;
    wmm_pkg::item_t   item = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    wmm_pkg::result_t result;

    wildcard_mask_match_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    wmm_pkg::item_t   pending[$];
    wmm_pkg::result_t expected_q[$];
    int unsigned      send_idle_pct = 0;
    int unsigned      recv_idle_pct = 0;
    int unsigned      fail_count = 0;
    int unsigned      results_seen = 0;
    int unsigned      hold_left = 0;
    bit               hold_done = 1'b0;
    wmm_pkg::result_t want;

    logic [7:0]     pat_bytes [wmm_pkg::MASK_LEN];
    int unsigned    pat_len = 0;
    bit             pat_ovf = 1'b0;
    wmm_pkg::live_t live = wmm_pkg::LIVE_W'(1);

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= wmm_pkg::CH_UPPER_A && c <= wmm_pkg::CH_UPPER_Z)
        begin
            return c + wmm_pkg::CASE_OFFSET;
        end
        return c;
    endfunction

    function automatic wmm_pkg::live_t spread_stars(input wmm_pkg::live_t s);
        wmm_pkg::live_t r;
        r = s;
        for (int p = 0; p < pat_len; p++)
        begin
            if (r[p] && pat_bytes[p] == wmm_pkg::CH_STAR)
            begin
                r[p + 1] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic wmm_pkg::live_t step_name(input wmm_pkg::live_t s,
                                                 input logic [7:0] c);
        wmm_pkg::live_t cur;
        wmm_pkg::live_t nxt;
        cur = spread_stars(s);
        nxt = '0;
        for (int p = 0; p < pat_len; p++)
        begin
            if (cur[p])
            begin
                if (pat_bytes[p] == wmm_pkg::CH_STAR)
                begin
                    nxt[p] = 1'b1;
                end
                else if (pat_bytes[p] == wmm_pkg::CH_QMARK
                        || fold_case(pat_bytes[p]) == fold_case(c))
                begin
                    nxt[p + 1] = 1'b1;
                end
            end
        end
        return nxt;
    endfunction

    task automatic predict_match(input wmm_pkg::item_t it);
        wmm_pkg::live_t   s;
        wmm_pkg::result_t exp_res;
        case (it.cmd)
            wmm_pkg::CMD_CLEAR:
            begin
                pat_len = 0;
                pat_ovf = 1'b0;
                live = wmm_pkg::LIVE_W'(1);
            end
            wmm_pkg::CMD_APPEND:
            begin
                if (pat_len < wmm_pkg::MASK_LEN)
                begin
                    pat_bytes[pat_len] = it.data;
                    pat_len++;
                end
                else
                begin
                    pat_ovf = 1'b1;
                end
                live = wmm_pkg::LIVE_W'(1);
            end
            wmm_pkg::CMD_NAME:
            begin
                live = step_name(live, it.data);
            end
            default:
            begin
                s = spread_stars(live);
                exp_res.matched = s[pat_len] && !pat_ovf;
                exp_res.mask_overflow = pat_ovf;
                expected_q.push_back(exp_res);
                live = wmm_pkg::LIVE_W'(1);
            end
        endcase
    endtask

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("%s", msg);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item <= '0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                predict_match(item);
            end
            if (!item_valid || !item_stall)
            begin
                if (pending.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    item_valid <= 1'b1;
                    item <= pending.pop_front();
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                note_failure($sformatf("unexpected result: matched=%0b overflow=%0b",
                    result.matched, result.mask_overflow));
            end
            else
            begin
                want = expected_q.pop_front();
                if (result.matched !== want.matched
                        || result.mask_overflow !== want.mask_overflow)
                begin
                    note_failure($sformatf(
                        "mismatch: expected matched=%0b overflow=%0b, %s",
                        want.matched, want.mask_overflow,
                        $sformatf("got matched=%0b overflow=%0b",
                            result.matched, result.mask_overflow)));
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (!hold_done && results_seen >= 4)
        begin
            hold_done = 1'b1;
            hold_left = 89;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    task automatic add(input wmm_pkg::cmd_t c, input logic [7:0] d);
        wmm_pkg::item_t it;
        it.cmd = c;
        it.data = d;
        pending.push_back(it);
    endtask

    function automatic logic [7:0] pick_letter();
        case ($urandom_range(0, 3))
            0: return "a";
            1: return "b";
            2: return "A";
            default: return "B";
        endcase
    endfunction

    function automatic logic [7:0] pick_mask_byte();
        case ($urandom_range(0, 9))
            0, 1: return wmm_pkg::CH_STAR;
            2: return wmm_pkg::CH_QMARK;
            3: return 8'($urandom_range(0, 255));
            default: return pick_letter();
        endcase
    endfunction

    function automatic logic [7:0] pick_name_byte();
        if ($urandom_range(0, 3) == 0)
        begin
            return 8'($urandom_range(0, 255));
        end
        return pick_letter();
    endfunction

    function automatic logic [7:0] flip_case(input logic [7:0] c);
        if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))
                && $urandom_range(0, 1) == 1)
        begin
            return c ^ 8'h20;
        end
        return c;
    endfunction

    task automatic add_sequence(input bit force_ovf);
        logic [7:0]  m[$];
        logic [7:0]  nm[$];
        int unsigned len;
        int unsigned r;
        int unsigned idx;
        logic [7:0]  b;
        add(wmm_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)));
        r = $urandom_range(0, 19);
        if (force_ovf)
        begin
            len = $urandom_range(wmm_pkg::MASK_LEN + 1, wmm_pkg::MASK_LEN + 4);
        end
        else if (r < 14)
        begin
            len = $urandom_range(0, 6);
        end
        else if (r < 18)
        begin
            len = $urandom_range(7, 16);
        end
        else
        begin
            len = $urandom_range(17, wmm_pkg::MASK_LEN);
        end
        for (int i = 0; i < len; i++)
        begin
            b = pick_mask_byte();
            m.push_back(b);
            add(wmm_pkg::CMD_APPEND, b);
        end
        repeat ($urandom_range(1, 4))
        begin
            nm.delete();
            foreach (m[i])
            begin
                if (m[i] == wmm_pkg::CH_STAR)
                begin
                    repeat ($urandom_range(0, 3)) nm.push_back(pick_name_byte());
                end
                else if (m[i] == wmm_pkg::CH_QMARK)
                begin
                    nm.push_back(8'($urandom_range(0, 255)));
                end
                else
                begin
                    nm.push_back(flip_case(m[i]));
                end
            end
            if ($urandom_range(0, 2) == 0)
            begin
                idx = (nm.size() > 0) ? $urandom_range(0, nm.size() - 1) : 0;
                case ($urandom_range(0, 2))
                    0: if (nm.size() > 0) nm[idx] = pick_name_byte();
                    1: if (nm.size() > 0) nm.delete(idx);
                    default: nm.insert(idx, pick_name_byte());
                endcase
            end
            foreach (nm[i]) add(wmm_pkg::CMD_NAME, nm[i]);
            add(wmm_pkg::CMD_END, 8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 4) == 0)
        begin
            repeat ($urandom_range(1, 4))
            begin
                add(wmm_pkg::cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic fill_random(input int unsigned count);
        int unsigned seq_no;
        seq_no = 0;
        while (pending.size() < count)
        begin
            add_sequence(seq_no % 9 == 4);
            seq_no++;
        end
    endtask

    task automatic drain();
        while (pending.size() > 0 || item_valid || expected_q.size() > 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 32;
        recv_idle_pct = 52;
        add(wmm_pkg::CMD_END, 8'hFF);
        add(wmm_pkg::CMD_NAME, "x");
        add(wmm_pkg::CMD_END, 8'h00);
        add(wmm_pkg::CMD_APPEND, wmm_pkg::CH_STAR);
        add(wmm_pkg::CMD_END, 8'h55);
        add(wmm_pkg::CMD_NAME, 8'h00);
        add(wmm_pkg::CMD_NAME, 8'hFF);
        add(wmm_pkg::CMD_END, 8'hAA);
        add(wmm_pkg::CMD_CLEAR, 8'hFF);
        add(wmm_pkg::CMD_APPEND, "A");
        add(wmm_pkg::CMD_APPEND, wmm_pkg::CH_QMARK);
        add(wmm_pkg::CMD_APPEND, 8'h00);
        add(wmm_pkg::CMD_APPEND, "z");
        add(wmm_pkg::CMD_NAME, "a");
        add(wmm_pkg::CMD_NAME, 8'hFF);
        add(wmm_pkg::CMD_NAME, 8'h00);
        add(wmm_pkg::CMD_NAME, "Z");
        add(wmm_pkg::CMD_END, 8'h00);
        add(wmm_pkg::CMD_NAME, "a");
        add(wmm_pkg::CMD_END, 8'h0F);
        add(wmm_pkg::CMD_CLEAR, 8'h00);
        add(wmm_pkg::CMD_APPEND, "[");
        add(wmm_pkg::CMD_NAME, "{");
        add(wmm_pkg::CMD_END, 8'hF0);
        fill_random(135);
        drain();

        send_idle_pct = 52;
        recv_idle_pct = 32;
        fill_random(135);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        fill_random(135);
        drain();

        repeat (8) @(posedge clk);
        if (fail_count == 0 && expected_q.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/wmm_pkg.sv
sv/wmm_mask_store.sv
sv/wmm_nfa.sv
sv/wildcard_mask_match_unit.sv
tb/testbench.sv
